[design/tdf_pkg.sv]
// Shared types and constants of the trial-division factorizer.
package tdf_pkg;

   localparam int FIRST_PRIME = 2;
   localparam int MAX_RESULTS = 31;
   localparam int COUNT_WIDTH = $clog2(MAX_RESULTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMIT_NONE,
      ST_CHECK,
      ST_DIVIDE,
      ST_DECIDE,
      ST_EMIT_FACTOR,
      ST_EMIT_FINAL
   } state_type;

   typedef struct packed {
      logic last;
      logic no_factors;
   } rsp_flags_type;

endpackage

[design/tdf_front.sv]
// Front stage: registers each incoming number and classifies it as trivial or as a job.
module tdf_front #(
   parameter int VALUE_WIDTH = 31
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_number,
   output logic                   push_valid,
   input  logic                   push_ready,
   output logic [VALUE_WIDTH-1:0] push_number,
   output logic                   push_trivial
);

   logic                   valid_ff, valid_in;
   logic [VALUE_WIDTH-1:0] number_ff, number_in;
   logic                   trivial_ff, trivial_in;
   logic                   accept;
   logic                   push;

   assign push      = valid_ff && push_ready;
   assign req_stall = valid_ff && !push_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in   = valid_ff;
      number_in  = number_ff;
      trivial_in = trivial_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in   = 1'b1;
         number_in  = req_number;
         trivial_in = req_number < VALUE_WIDTH'(tdf_pkg::FIRST_PRIME);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      number_ff  <= number_in;
      trivial_ff <= trivial_in;
   end

   assign push_valid   = valid_ff;
   assign push_number  = number_ff;
   assign push_trivial = trivial_ff;

endmodule

[design/tdf_queue.sv]
// Short job queue between the front stage and the factorizing engine.
module tdf_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_pop,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     store_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 do_write;
   logic                 do_read;

   assign wr_ready = count_ff != CNT_WIDTH'(DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_data  = store_ff[rd_ptr_ff];
   assign do_write = wr_valid && wr_ready;
   assign do_read  = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_write && !do_read) begin
         count_in = count_ff + 1'b1;
      end else if (do_read && !do_write) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_write) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(DEPTH))
      else $error("Queue occupancy exceeds its depth.");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("Empty queue with differing pointers.");

endmodule

[design/tdf_back.sv]
// Factorizing engine: trial divisors with a bit-serial divider and a result register.
module tdf_back #(
   parameter int VALUE_WIDTH = 31
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_pop,
   input  logic [VALUE_WIDTH-1:0] job_number,
   input  logic                   job_trivial,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_WIDTH-1:0] rsp_factor,
   output logic                   rsp_last,
   output logic                   rsp_no_factors
);

   localparam int W         = VALUE_WIDTH;
   localparam int BIT_WIDTH = $clog2(W);
   localparam int CW        = tdf_pkg::COUNT_WIDTH;

   tdf_pkg::state_type     state_ff, state_in;
   logic [W-1:0]           rem_ff, rem_in;
   logic [W-1:0]           div_ff, div_in;
   logic [W:0]             sq_ff, sq_in;
   logic [W-1:0]           part_ff, part_in;
   logic [W-1:0]           quot_ff, quot_in;
   logic [BIT_WIDTH-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]           rsp_factor_ff, rsp_factor_in;
   tdf_pkg::rsp_flags_type rsp_flags_ff, rsp_flags_in;

   logic                   out_free;
   logic                   load;
   logic                   at_cap;
   logic [W:0]             shifted;
   logic [W:0]             diff;
   logic                   fits;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign at_cap   = count_ff == CW'(tdf_pkg::MAX_RESULTS - 1);
   assign shifted  = {part_ff, quot_ff[W-1]};
   assign fits     = shifted >= {1'b0, div_ff};
   assign diff     = shifted - {1'b0, div_ff};

   always_comb begin
      state_in      = state_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      sq_in         = sq_ff;
      part_in       = part_ff;
      quot_in       = quot_ff;
      bit_cnt_in    = bit_cnt_ff;
      count_in      = count_ff;
      rsp_factor_in = rsp_factor_ff;
      rsp_flags_in  = rsp_flags_ff;
      load          = 1'b0;
      job_pop       = 1'b0;
      unique case (state_ff)
         tdf_pkg::ST_IDLE: begin
            job_pop = job_valid;
            if (job_valid) begin
               if (job_trivial) begin
                  state_in = tdf_pkg::ST_EMIT_NONE;
               end else begin
                  rem_in   = job_number;
                  div_in   = W'(tdf_pkg::FIRST_PRIME);
                  sq_in    = (W + 1)'(tdf_pkg::FIRST_PRIME * tdf_pkg::FIRST_PRIME);
                  count_in = '0;
                  state_in = tdf_pkg::ST_CHECK;
               end
            end
         end
         tdf_pkg::ST_EMIT_NONE: begin
            if (out_free) begin
               load                    = 1'b1;
               rsp_factor_in           = '0;
               rsp_flags_in.last       = 1'b1;
               rsp_flags_in.no_factors = 1'b1;
               state_in                = tdf_pkg::ST_IDLE;
            end
         end
         tdf_pkg::ST_CHECK: begin
            if (sq_ff > {1'b0, rem_ff}) begin
               state_in = tdf_pkg::ST_EMIT_FINAL;
            end else begin
               part_in    = '0;
               quot_in    = rem_ff;
               bit_cnt_in = BIT_WIDTH'(W - 1);
               state_in   = tdf_pkg::ST_DIVIDE;
            end
         end
         tdf_pkg::ST_DIVIDE: begin
            part_in    = fits ? diff[W-1:0] : shifted[W-1:0];
            quot_in    = {quot_ff[W-2:0], fits};
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               state_in = tdf_pkg::ST_DECIDE;
            end
         end
         tdf_pkg::ST_DECIDE: begin
            if (part_ff == '0) begin
               state_in = tdf_pkg::ST_EMIT_FACTOR;
            end else begin
               div_in   = div_ff + 1'b1;
               sq_in    = sq_ff + {div_ff, 1'b1};
               state_in = tdf_pkg::ST_CHECK;
            end
         end
         tdf_pkg::ST_EMIT_FACTOR: begin
            if (out_free) begin
               load                    = 1'b1;
               rsp_factor_in           = div_ff;
               rsp_flags_in.last       = at_cap;
               rsp_flags_in.no_factors = 1'b0;
               rem_in                  = quot_ff;
               count_in                = count_ff + 1'b1;
               state_in                = at_cap ? tdf_pkg::ST_IDLE : tdf_pkg::ST_CHECK;
            end
         end
         tdf_pkg::ST_EMIT_FINAL: begin
            if (out_free) begin
               load                    = 1'b1;
               rsp_factor_in           = rem_ff;
               rsp_flags_in.last       = 1'b1;
               rsp_flags_in.no_factors = 1'b0;
               state_in                = tdf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdf_pkg::ST_IDLE;
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      sq_ff         <= sq_in;
      part_ff       <= part_in;
      quot_ff       <= quot_in;
      bit_cnt_ff    <= bit_cnt_in;
      count_ff      <= count_in;
      rsp_factor_ff <= rsp_factor_in;
      rsp_flags_ff  <= rsp_flags_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_factor     = rsp_factor_ff;
   assign rsp_last       = rsp_flags_ff.last;
   assign rsp_no_factors = rsp_flags_ff.no_factors;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdf_pkg::ST_DIVIDE) |-> (div_ff >= W'(tdf_pkg::FIRST_PRIME)))
      else $error("Trial divisor below the first prime during division.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flags_ff.no_factors) |-> (rsp_factor_ff == '0 && rsp_flags_ff.last))
      else $error("Empty-factor result without a zero factor and last mark.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_flags_ff.no_factors) |->
         (rsp_factor_ff >= W'(tdf_pkg::FIRST_PRIME)))
      else $error("Emitted factor below the first prime.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != tdf_pkg::ST_IDLE && state_ff != tdf_pkg::ST_EMIT_NONE) |->
         (count_ff < CW'(tdf_pkg::MAX_RESULTS)))
      else $error("Factor count passed the result limit within a run.");

endmodule

[design/trial_division_factorizer.sv]
// Top level of the trial-division prime factorizer.
// Usage: each transaction on the req_ channel carries one number; the block answers with
// its prime factors in ascending order, one rsp_ transaction per factor, repeated by
// multiplicity, with rsp_last set on the final one. Numbers 0 and 1 give a single
// transaction with rsp_factor zero and both rsp_last and rsp_no_factors set.
// A front stage registers and classifies numbers and feeds a short queue; the engine
// behind it takes one number at a time. Each trial divisor is tested by a check state,
// the one-bit-per-cycle restoring divider and a decide state, and each emitted factor
// takes an emit state as well. Every trial divisor that the divider uses is at most the
// square root of the number, and a trivial number (0 or 1) skips the divider.
// Further numbers are accepted until the front register and queue are full.
// A stalled rsp_ transaction is held unchanged and the engine waits to emit its next
// result; req_stall rises once the queue and front register have filled. Reset clears
// the queue, the engine and the result register; no transaction is in flight afterwards.
module trial_division_factorizer #(
   parameter int VALUE_WIDTH = 31,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_number,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_WIDTH-1:0] rsp_factor,
   output logic                   rsp_last,
   output logic                   rsp_no_factors
);

   logic                   push_valid;
   logic                   push_ready;
   logic [VALUE_WIDTH-1:0] push_number;
   logic                   push_trivial;
   logic                   job_valid;
   logic                   job_pop;
   logic [VALUE_WIDTH:0]   job_data;

   tdf_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_number  (req_number),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_number (push_number),
      .push_trivial(push_trivial)
   );

   tdf_queue #(
      .WIDTH(VALUE_WIDTH + 1),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_valid(push_valid),
      .wr_ready(push_ready),
      .wr_data ({push_trivial, push_number}),
      .rd_valid(job_valid),
      .rd_pop  (job_pop),
      .rd_data (job_data)
   );

   tdf_back #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job_pop       (job_pop),
      .job_number    (job_data[VALUE_WIDTH-1:0]),
      .job_trivial   (job_data[VALUE_WIDTH]),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_factor    (rsp_factor),
      .rsp_last      (rsp_last),
      .rsp_no_factors(rsp_no_factors)
   );

endmodule

[tb/sv/trial_division_factorizer_test.sv]
// Self-checking testbench for the trial-division prime factorizer.
`timescale 1ns / 1ps

module trial_division_factorizer_test;

   localparam int VW = 31;
   localparam int NUM_DIRECTED = 16;
   localparam int RANDOM_ITEMS = 100;
   localparam int IDLE_PERCENT = 16;
   localparam int SETTLE_CYCLES = 100;

   typedef struct packed {
      logic [VW-1:0] factor;
      logic last;
      logic no_factors;
   } factor_result_type;

   typedef struct packed {
      logic [VW-1:0] number;
      logic typed;
      logic [VW-1:0] solo_factor;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [VW-1:0] req_number = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [VW-1:0] rsp_factor;
   logic rsp_last;
   logic rsp_no_factors;

   factor_result_type pending_factors[$];
   int mismatches = 0;
   int factors_checked = 0;
   int numbers_sent = 0;
   bit no_idle = 1'b0;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{31'd0, 1'b1, 31'd0},
      '{31'd1, 1'b1, 31'd0},
      '{31'd2, 1'b1, 31'd2},
      '{31'd3, 1'b1, 31'd3},
      '{31'd4, 1'b0, 31'd0},
      '{31'd1, 1'b1, 31'd0},
      '{31'd49, 1'b0, 31'd0},
      '{31'd97, 1'b1, 31'd97},
      '{31'd194, 1'b0, 31'd0},
      '{31'd30030, 1'b0, 31'd0},
      '{31'd1073741824, 1'b0, 31'd0},
      '{31'd2147483646, 1'b0, 31'd0},
      '{31'd1073741823, 1'b0, 31'd0},
      '{31'd2147483647, 1'b1, 31'd2147483647},
      '{31'd0, 1'b1, 31'd0},
      '{31'd961, 1'b0, 31'd0}
   };

   trial_division_factorizer #(
      .VALUE_WIDTH(VW)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_number(req_number),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_factor(rsp_factor),
      .rsp_last(rsp_last),
      .rsp_no_factors(rsp_no_factors)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic predict_factors(input logic [VW-1:0] number);
      factor_result_type found[$];
      factor_result_type entry;
      logic [VW-1:0] rest;
      logic [VW-1:0] divisor;
      logic [2*VW-1:0] square;
      if (number < tdf_pkg::FIRST_PRIME) begin
         entry = '{factor: '0, last: 1'b1, no_factors: 1'b1};
         pending_factors.push_back(entry);
         return;
      end
      rest = number;
      divisor = VW'(tdf_pkg::FIRST_PRIME);
      square = {{VW{1'b0}}, divisor} * {{VW{1'b0}}, divisor};
      while (found.size() < tdf_pkg::MAX_RESULTS && square <= {{VW{1'b0}}, rest}) begin
         if (rest % divisor == '0) begin
            entry = '{factor: divisor, last: 1'b0, no_factors: 1'b0};
            found.push_back(entry);
            rest = rest / divisor;
         end else begin
            divisor = divisor + 1'b1;
            square = {{VW{1'b0}}, divisor} * {{VW{1'b0}}, divisor};
         end
      end
      if (found.size() < tdf_pkg::MAX_RESULTS && rest > 1) begin
         entry = '{factor: rest, last: 1'b0, no_factors: 1'b0};
         found.push_back(entry);
      end
      found[found.size() - 1].last = 1'b1;
      foreach (found[i]) pending_factors.push_back(found[i]);
   endtask

   // Small numbers, shifted bytes and products of small multipliers with at most one cofactor
   // below 2^14 keep the largest trial divisor near 128.
   function automatic logic [VW-1:0] random_number();
      longint unsigned value;
      longint unsigned multiplier;
      int choice;
      choice = $urandom_range(99);
      if (choice < 10) return VW'($urandom_range(40));
      if (choice < 25) return VW'($urandom_range(1, 255)) << $urandom_range(23);
      value = 1;
      repeat ($urandom_range(1, 6)) begin
         multiplier = $urandom_range(2, 127);
         if (value * multiplier < (64'd1 << VW)) value = value * multiplier;
      end
      if ($urandom_range(1)) begin
         multiplier = $urandom_range(2, 16383);
         if (value * multiplier < (64'd1 << VW)) value = value * multiplier;
      end
      return VW'(value);
   endfunction

   task automatic send_number(input logic [VW-1:0] number, input logic typed,
                              input logic [VW-1:0] solo_factor);
      factor_result_type entry;
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_number <= number;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      numbers_sent++;
      if (typed) begin
         entry = '{factor: solo_factor, last: 1'b1, no_factors: solo_factor == '0};
         pending_factors.push_back(entry);
      end else begin
         predict_factors(number);
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= !no_idle && !reset && $urandom_range(99) < IDLE_PERCENT;
   end

   always @(posedge clock) begin
      factor_result_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_factors.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction, factor %0d", rsp_factor));
         end else begin
            expected = pending_factors.pop_front();
            factors_checked++;
            if (rsp_factor !== expected.factor)
               report_mismatch($sformatf("factor %0d, expected %0d",
                                         rsp_factor, expected.factor));
            if (rsp_last !== expected.last)
               report_mismatch($sformatf("last %b, expected %b", rsp_last, expected.last));
            if (rsp_no_factors !== expected.no_factors)
               report_mismatch($sformatf("no_factors %b, expected %b",
                                         rsp_no_factors, expected.no_factors));
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int row = 0; row < NUM_DIRECTED; row++) begin
         send_number(directed_rows[row].number, directed_rows[row].typed,
                     directed_rows[row].solo_factor);
      end
      req_valid <= 1'b0;
      while (pending_factors.size() != 0) @(posedge clock);
      for (int item = 0; item < RANDOM_ITEMS; item++) begin
         no_idle = item >= 40 && item < 70;
         send_number(random_number(), 1'b0, '0);
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;
      while (pending_factors.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_factors.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_factors.size()));
      $display("Factorized %0d numbers and checked %0d factor transactions,",
               numbers_sent, factors_checked);
      $display("from zero and one through small composites to the largest 31-bit prime.");
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("Verification failed");
      $finish;
   end

endmodule
